### rtl/core/lfu_pkg.sv
// Package for the LFU cache: sizes, entry record and sequencer states.
// Used by lfu_engine and lfu_cache.
package lfu_pkg;
    localparam int CapacityMax = 16;
    localparam int CountWidth = 16;
    localparam int StampWidth = 48;
    localparam int IdxWidth = $clog2(CapacityMax);
    localparam int CapWidth = 5;
    localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

    localparam logic CmdGet = 1'b0;
    localparam logic CmdPut = 1'b1;

    typedef struct packed {
        logic [31:0]           key;
        logic [31:0]           value;
        logic [CountWidth-1:0] count;
        logic [StampWidth-1:0] stamp;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_WRITE,
        ST_OUT
    } state_t;
endpackage

### rtl/core/lfu_engine.sv
// Sequencer for the LFU cache: scans the entry memory one entry a cycle,
// then writes back at most one entry. Depends on lfu_pkg.
module lfu_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [lfu_pkg::CapWidth-1:0]      capacity,
    input  logic                              start,
    input  logic                              cmd,
    input  logic [31:0]                       key,
    input  logic [31:0]                       value,
    output logic                              busy,
    output logic                              done,
    output logic                              hit,
    output logic [31:0]                       read_value
);
    localparam int IW = lfu_pkg::IdxWidth;
    localparam int CW = lfu_pkg::CapWidth;

    lfu_pkg::entry_t mem [lfu_pkg::CapacityMax];
    lfu_pkg::entry_t rd_reg;
    lfu_pkg::entry_t wr_data;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;

    lfu_pkg::state_t state_reg, state_next;
    logic [lfu_pkg::CapacityMax-1:0] valid_reg;
    logic [lfu_pkg::StampWidth-1:0]  clock_reg;
    logic [CW-1:0]   used_reg;
    logic [IW:0]     scan_reg, scan_next;
    logic [IW-1:0]   cur_reg;
    logic            cmd_reg;
    logic [31:0]     key_reg, value_reg;
    logic            found_reg;
    logic [IW-1:0]   found_idx_reg;
    lfu_pkg::entry_t found_ent_reg;
    logic            vic_ok_reg;
    logic [IW-1:0]   vic_idx_reg;
    lfu_pkg::entry_t vic_ent_reg;
    logic            hit_reg;
    logic [31:0]     rv_reg;
    logic            free_ok;
    logic [IW-1:0]   free_idx;
    logic [CW-1:0]   cap;
    logic            cur_valid;
    logic            better;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_addr = scan_reg[IW-1:0];
    assign cap = (capacity > CW'(lfu_pkg::CapacityMax)) ? CW'(lfu_pkg::CapacityMax) : capacity;
    assign cur_valid = valid_reg[cur_reg];
    assign better = !vic_ok_reg || rd_reg.count < vic_ent_reg.count ||
                    (rd_reg.count == vic_ent_reg.count && rd_reg.stamp < vic_ent_reg.stamp);

    always_comb begin
        free_ok = 1'b0;
        free_idx = '0;
        for (int i = lfu_pkg::CapacityMax - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_ok = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        scan_next = scan_reg;
        case (state_reg)
            lfu_pkg::ST_IDLE: begin
                scan_next = '0;
                if (start) begin
                    state_next = lfu_pkg::ST_SCAN;
                    scan_next = (IW+1)'(1);
                end
            end
            lfu_pkg::ST_SCAN: begin
                if (scan_reg == (IW+1)'(lfu_pkg::CapacityMax)) begin
                    state_next = lfu_pkg::ST_LAST;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            lfu_pkg::ST_LAST: state_next = lfu_pkg::ST_WRITE;
            lfu_pkg::ST_WRITE: state_next = lfu_pkg::ST_OUT;
            lfu_pkg::ST_OUT: state_next = lfu_pkg::ST_IDLE;
            default: state_next = lfu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        wr_en = 1'b0;
        wr_addr = found_idx_reg;
        wr_data = found_ent_reg;
        if (state_reg == lfu_pkg::ST_WRITE) begin
            if (found_reg) begin
                if (cmd_reg == lfu_pkg::CmdGet || cap != '0) begin
                    wr_en = 1'b1;
                    if (cmd_reg == lfu_pkg::CmdPut) begin
                        wr_data.value = value_reg;
                    end
                    if (found_ent_reg.count != lfu_pkg::CountMax) begin
                        wr_data.count = found_ent_reg.count + 1'b1;
                    end
                    wr_data.stamp = clock_reg;
                end
            end else if (cmd_reg == lfu_pkg::CmdPut && cap != '0) begin
                wr_data.key = key_reg;
                wr_data.value = value_reg;
                wr_data.count = lfu_pkg::CountWidth'(1);
                wr_data.stamp = clock_reg;
                if (used_reg >= cap && vic_ok_reg) begin
                    wr_en = 1'b1;
                    wr_addr = vic_idx_reg;
                end else if (free_ok) begin
                    wr_en = 1'b1;
                    wr_addr = free_idx;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lfu_pkg::ST_IDLE;
            valid_reg <= '0;
            clock_reg <= '0;
            used_reg <= '0;
            scan_reg <= '0;
        end else begin
            state_reg <= state_next;
            scan_reg <= scan_next;
            if (wr_en) begin
                clock_reg <= clock_reg + 1'b1;
                if (!found_reg && !(used_reg >= cap && vic_ok_reg)) begin
                    valid_reg[wr_addr] <= 1'b1;
                    used_reg <= used_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == lfu_pkg::ST_IDLE && start) begin
            cmd_reg <= cmd;
            key_reg <= key;
            value_reg <= value;
            found_reg <= 1'b0;
            vic_ok_reg <= 1'b0;
            cur_reg <= '0;
        end
        if (state_reg == lfu_pkg::ST_SCAN || state_reg == lfu_pkg::ST_LAST) begin
            cur_reg <= cur_reg + 1'b1;
            if (cur_valid) begin
                if (!found_reg && rd_reg.key == key_reg) begin
                    found_reg <= 1'b1;
                    found_idx_reg <= cur_reg;
                    found_ent_reg <= rd_reg;
                end
                if (better) begin
                    vic_ok_reg <= 1'b1;
                    vic_idx_reg <= cur_reg;
                    vic_ent_reg <= rd_reg;
                end
            end
        end
        if (state_reg == lfu_pkg::ST_WRITE) begin
            hit_reg <= found_reg;
            if (cmd_reg == lfu_pkg::CmdPut) begin
                rv_reg <= '0;
            end else if (found_reg) begin
                rv_reg <= found_ent_reg.value;
            end else begin
                rv_reg <= '1;
            end
        end
    end

    assign busy = state_reg != lfu_pkg::ST_IDLE;
    assign done = state_reg == lfu_pkg::ST_OUT;
    assign hit = hit_reg;
    assign read_value = rv_reg;
endmodule

### rtl/core/lfu_cache.sv
// Top level of the LFU cache: stream ports, capacity register, output register.
// Depends on lfu_pkg and lfu_engine.
//
// Usage: send an item on s_axis (cmd get/put, key, value); one result per item
// comes out on m_axis (hit, read_value). read_value is the stored value on a
// get hit, all ones on a get miss, zero on a put.
// The entry memory has one read port, so for each item the sequencer reads all
// 16 entries one after another through a registered read, then writes back at
// most one entry and loads the result. A new item is accepted while the
// previous result still waits in the output register, once the sequencer is
// idle; only one item is in work at a time.
// If the receiver stalls, the finished result holds and at most one further
// item completes before s_axis_tready drops.
// Reset clears all entry valid bits, the use clock, the occupancy and sets the
// capacity to 16. cfg_we writes the capacity; write only while idle.
module lfu_cache (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,  // [0] cmd
    input  logic [63:0] s_axis_tdata,  // [31:0] key, [63:32] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic        m_axis_tuser,  // [0] hit
    output logic [31:0] m_axis_tdata   // [31:0] read_value
);
    logic [lfu_pkg::CapWidth-1:0] cap_reg;
    logic        busy, done, hit;
    logic [31:0] rv;
    logic        out_valid_reg;
    logic        out_hit_reg;
    logic [31:0] out_data_reg;
    logic        start;
    logic        hold_valid_reg;
    logic        hold_hit_reg;
    logic [31:0] hold_data_reg;

    assign s_axis_tready = !busy && !hold_valid_reg && aresetn;
    assign start = s_axis_tvalid && s_axis_tready;

    lfu_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .capacity   (cap_reg),
        .start      (start),
        .cmd        (s_axis_tuser),
        .key        (s_axis_tdata[31:0]),
        .value      (s_axis_tdata[63:32]),
        .busy       (busy),
        .done       (done),
        .hit        (hit),
        .read_value (rv)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= 5'd16;
            out_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (!out_valid_reg || m_axis_tready) begin
                if (hold_valid_reg) begin
                    out_valid_reg <= 1'b1;
                    out_hit_reg <= hold_hit_reg;
                    out_data_reg <= hold_data_reg;
                    hold_valid_reg <= done;
                    hold_hit_reg <= hit;
                    hold_data_reg <= rv;
                end else begin
                    out_valid_reg <= done;
                    out_hit_reg <= hit;
                    out_data_reg <= rv;
                end
            end else if (done) begin
                hold_valid_reg <= 1'b1;
                hold_hit_reg <= hit;
                hold_data_reg <= rv;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser = out_hit_reg;
    assign m_axis_tdata = out_data_reg;
endmodule

### bench/lfu_cache_chk.sv
`timescale 1ns / 100ps
// Checker for lfu_cache: watches both stream channels, predicts each result with
// its own LFU cache model and compares. Depends on lfu_pkg.
module lfu_cache_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        s_axis_tuser,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        m_axis_tuser,
    input  logic [31:0] m_axis_tdata,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic        hit;
        logic [31:0] rdata;
    } lookup_t;

    logic                           slot_valid [lfu_pkg::CapacityMax];
    lfu_pkg::entry_t                slot       [lfu_pkg::CapacityMax];
    logic [lfu_pkg::StampWidth-1:0] use_clock;
    int                             occupancy;
    logic [4:0]                     cap_reg;
    lookup_t                        lookups_due[$];

    assign pending = lookups_due.size();

    function automatic void touch_slot(int i);
        slot[i].stamp = use_clock;
        use_clock     = use_clock + 1'b1;
    endfunction

    function automatic void bump_slot(int i);
        if (slot[i].count != lfu_pkg::CountMax)
            slot[i].count = slot[i].count + 1'b1;
        touch_slot(i);
    endfunction

    function automatic lookup_t cache_access(logic cmd, logic [31:0] k, logic [31:0] v);
        lookup_t r;
        int      idx;
        int      victim;
        int      cap;
        idx    = -1;
        victim = -1;
        cap    = (cap_reg > lfu_pkg::CapacityMax) ? lfu_pkg::CapacityMax : int'(cap_reg);
        for (int i = 0; i < lfu_pkg::CapacityMax; i++)
            if (idx < 0 && slot_valid[i] && slot[i].key == k)
                idx = i;
        r.hit   = (idx >= 0);
        r.rdata = '0;
        if (cmd == lfu_pkg::CmdGet) begin
            if (idx >= 0) begin
                r.rdata = slot[idx].value;
                bump_slot(idx);
            end else begin
                r.rdata = '1;
            end
        end else if (cap != 0) begin
            if (idx >= 0) begin
                slot[idx].value = v;
                bump_slot(idx);
            end else begin
                if (occupancy >= cap) begin
                    for (int i = 0; i < lfu_pkg::CapacityMax; i++) begin
                        if (!slot_valid[i])
                            continue;
                        if (victim < 0 || slot[i].count < slot[victim].count ||
                            (slot[i].count == slot[victim].count &&
                             slot[i].stamp < slot[victim].stamp))
                            victim = i;
                    end
                    if (victim >= 0) begin
                        slot_valid[victim] = 1'b0;
                        occupancy--;
                    end
                end
                if (victim < 0)
                    for (int i = 0; i < lfu_pkg::CapacityMax; i++)
                        if (victim < 0 && !slot_valid[i])
                            victim = i;
                if (victim >= 0) begin
                    slot_valid[victim]  = 1'b1;
                    slot[victim].key    = k;
                    slot[victim].value  = v;
                    slot[victim].count  = lfu_pkg::CountWidth'(1);
                    touch_slot(victim);
                    occupancy++;
                end
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        lookup_t want;
        if (!aresetn) begin
            for (int i = 0; i < lfu_pkg::CapacityMax; i++)
                slot_valid[i] = 1'b0;
            use_clock  = '0;
            occupancy  = 0;
            cap_reg    = 5'd16;
            fail_count = 0;
            lookups_due.delete();
        end else begin
            if (cfg_we)
                cap_reg = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                if (lookups_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result hit=%0b data=%h", m_axis_tuser,
                                 m_axis_tdata);
                end else begin
                    want = lookups_due.pop_front();
                    if (want.hit !== m_axis_tuser || want.rdata !== m_axis_tdata) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected hit=%0b data=%h, got hit=%0b data=%h",
                                     want.hit, want.rdata, m_axis_tuser, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                lookups_due.push_back(cache_access(s_axis_tuser, s_axis_tdata[31:0],
                                                   s_axis_tdata[63:32]));
        end
    end
endmodule

### bench/lfu_cache_tb.sv
`timescale 1ns / 100ps
// Top of the lfu_cache bench: clock, reset, capacity phases, stimulus and verdict.
// Depends on lfu_pkg, lfu_cache and lfu_cache_chk.
module lfu_cache_tb;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic        s_axis_tuser = 1'b0;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        m_axis_tuser;
    logic [31:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          hold_off = 1'b0;
    bit          done = 1'b0;
    logic [31:0] key_pool[8];

    lfu_cache i_dut (.*);
    lfu_cache_chk i_chk (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == 2000000 && !done) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always begin
        int g;
        @(posedge aclk);
        if (hold_off) begin
            m_axis_tready <= 1'b0;
            repeat (200) @(posedge aclk);
            hold_off = 1'b0;
        end
        g = gap_len();
        m_axis_tready <= (g == 0);
        if (g != 0) begin
            repeat (g) @(posedge aclk);
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_op(logic cmd, logic [31:0] k, logic [31:0] v, bit idle_ok);
        int g;
        g = idle_ok ? gap_len() : 0;
        if (g != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {v, k};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic set_capacity(logic [4:0] c);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        return ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)] : $urandom();
    endfunction

    task automatic random_phase(int n, logic [4:0] cap, int pool_span, bit stall);
        set_capacity(cap);
        if (stall)
            hold_off = 1'b1;
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom_range(0, pool_span) - (pool_span / 2);
        for (int i = 0; i < n; i++)
            send_op(1'($urandom_range(0, 1)), pick_key(), $urandom(), 1'b1);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_op(lfu_pkg::CmdGet, 32'h8000_0000, '0, 1'b0);
        send_op(lfu_pkg::CmdPut, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_op(lfu_pkg::CmdPut, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_op(lfu_pkg::CmdPut, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_op(lfu_pkg::CmdPut, 32'h0, 32'h0, 1'b0);
        send_op(lfu_pkg::CmdGet, 32'h8000_0000, '0, 1'b0);
        send_op(lfu_pkg::CmdGet, 32'h7FFF_FFFF, '0, 1'b0);
        send_op(lfu_pkg::CmdGet, 32'hFFFF_FFFF, '1, 1'b0);
        send_op(lfu_pkg::CmdPut, 32'h0, 32'h1234_5678, 1'b0);
        send_op(lfu_pkg::CmdGet, 32'h0, '0, 1'b0);
        set_capacity(5'd0);
        send_op(lfu_pkg::CmdPut, 32'h5, 32'h5, 1'b0);
        send_op(lfu_pkg::CmdPut, 32'h0, 32'h9, 1'b0);
        send_op(lfu_pkg::CmdGet, 32'h0, '0, 1'b0);
        send_op(lfu_pkg::CmdGet, 32'h5, '0, 1'b0);
        set_capacity(5'd31);
        for (int i = 0; i < 6; i++)
            send_op(lfu_pkg::CmdPut, 32'h100 + i, i, 1'b0);
        set_capacity(5'd2);
        send_op(lfu_pkg::CmdPut, 32'h200, 32'h1, 1'b0);
        send_op(lfu_pkg::CmdGet, 32'h0, '0, 1'b0);

        random_phase(150, 5'd4, 12, 1'b0);
        random_phase(150, 5'd16, 40, 1'b1);
        random_phase(120, 5'd1, 4, 1'b0);
        random_phase(150, 5'd8, 24, 1'b0);
        random_phase(80, 5'd0, 20, 1'b0);
        random_phase(150, 5'd20, 60, 1'b0);
        random_phase(100, 5'd3, 10, 1'b0);

        drain();
        done = 1'b1;
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
